/* rtl/qmr_pkg.sv */
package qmr_pkg;

  // operation codes carried by req_type
  localparam logic OP_PRODUCT = 1'b0;
  localparam logic OP_ROTATE  = 1'b1;

  // control of one term in a four-term dot product
  // neg_pre: negate the exact product before the floor shift
  // sub:     subtract the floored term instead of adding it
  typedef struct packed {
    logic neg_pre;
    logic sub;
  } term_ctl_t;

  localparam term_ctl_t T_ADD    = '{neg_pre: 1'b0, sub: 1'b0};
  localparam term_ctl_t T_SUB    = '{neg_pre: 1'b0, sub: 1'b1};
  localparam term_ctl_t T_NEGADD = '{neg_pre: 1'b1, sub: 1'b0};

endpackage

/* rtl/qmr_dot4.sv */
module qmr_dot4 #(
  parameter int PW   = 32,
  parameter int FRAC = 14
) (
  input  logic signed [PW-1:0]     prod_i [4],
  input  qmr_pkg::term_ctl_t       ctl_i  [4],
  output logic signed [PW+2-FRAC:0] sum_o
);

  localparam int TW = PW + 1 - FRAC;
  localparam int SW = PW + 3 - FRAC;

  logic signed [PW:0]   ext [4];
  logic signed [PW:0]   shf [4];
  logic signed [TW-1:0] trm [4];
  logic signed [SW-1:0] acc;

  always_comb begin
    acc = '0;
    for (int i = 0; i < 4; i++) begin
      ext[i] = {prod_i[i][PW-1], prod_i[i]};
      if (ctl_i[i].neg_pre) begin
        ext[i] = -ext[i];
      end
      // arithmetic shift floors toward minus infinity
      shf[i] = ext[i] >>> FRAC;
      trm[i] = shf[i][TW-1:0];
      if (ctl_i[i].sub) begin
        acc = acc - SW'(trm[i]);
      end else begin
        acc = acc + SW'(trm[i]);
      end
    end
  end

  assign sum_o = acc;

endmodule

/* rtl/quaternion_multiply_rotate_unit.sv */
// channel  | ports                                      | handshake
// request  | req_type_i, a_*_i, b_*_i                   | start_i && !busy_o
// result   | r_w_o, r_x_o, r_y_o, r_z_o, overflow_o     | done_o, one cycle
//
// one beat enters per cycle; busy_o stays low
// a beat passes through the input register, first multiply, first sum and clamp,
// second multiply, second sum and clamp into the output register
// the two multiply rounds of a rotation set the depth; a product request
// rides along through the second round unchanged
// reset clears only the valid bits; the receiver cannot stall, nothing waits
module quaternion_multiply_rotate_unit #(
  parameter int FRAC_BITS  = 14,
  parameter int DATA_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                         req_type_i,
  input  logic signed [DATA_WIDTH-1:0] a_w_i,
  input  logic signed [DATA_WIDTH-1:0] a_x_i,
  input  logic signed [DATA_WIDTH-1:0] a_y_i,
  input  logic signed [DATA_WIDTH-1:0] a_z_i,
  input  logic signed [DATA_WIDTH-1:0] b_w_i,
  input  logic signed [DATA_WIDTH-1:0] b_x_i,
  input  logic signed [DATA_WIDTH-1:0] b_y_i,
  input  logic signed [DATA_WIDTH-1:0] b_z_i,
  output logic                         done_o,
  output logic signed [DATA_WIDTH-1:0] r_w_o,
  output logic signed [DATA_WIDTH-1:0] r_x_o,
  output logic signed [DATA_WIDTH-1:0] r_y_o,
  output logic signed [DATA_WIDTH-1:0] r_z_o,
  output logic                         overflow_o
);

  localparam int DW  = DATA_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int IW  = DW + 4;          // rotation intermediate width
  localparam int PW1 = 2 * DW;          // a * b
  localparam int S1  = PW1 + 3 - F;
  localparam int PW2 = IW + DW + 1;     // t * (+/-a)
  localparam int S2  = PW2 + 3 - F;

  localparam logic signed [S1-1:0] S1_DMAX = {{(S1-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [S1-1:0] S1_DMIN = {{(S1-DW+1){1'b1}}, {(DW-1){1'b0}}};
  localparam logic signed [S1-1:0] S1_IMAX = {{(S1-IW+1){1'b0}}, {(IW-1){1'b1}}};
  localparam logic signed [S1-1:0] S1_IMIN = {{(S1-IW+1){1'b1}}, {(IW-1){1'b0}}};
  localparam logic signed [S2-1:0] S2_DMAX = {{(S2-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [S2-1:0] S2_DMIN = {{(S2-DW+1){1'b1}}, {(DW-1){1'b0}}};

  // stage 1: input register
  logic                 v1_q, op1_q;
  logic signed [DW-1:0] a1_q [4];
  logic signed [DW-1:0] b1_q [4];

  // stage 2: all sixteen a*b products
  logic                  v2_q, op2_q;
  logic signed [DW-1:0]  a2_q [4];
  logic signed [PW1-1:0] p2_d [4][4];
  logic signed [PW1-1:0] p2_q [4][4];

  // stage 3: first sums, clamped
  logic                  v3_q, op3_q, ov3_q;
  logic signed [DW:0]    qa3_d [4];
  logic signed [DW:0]    qa3_q [4];
  logic signed [PW1-1:0] sel_p [4][4];
  qmr_pkg::term_ctl_t    sel_c [4][4];
  logic signed [S1-1:0]  s1_sum [4];
  logic signed [S1-1:0]  s1_sat [4];
  logic signed [IW-1:0]  t3_d [4];
  logic signed [IW-1:0]  t3_q [4];
  logic                  ov3_d;

  // stage 4: second products
  logic                  v4_q, op4_q, ov4_q;
  logic signed [IW-1:0]  t4_q [4];
  logic signed [PW2-1:0] p4_d [3][4];
  logic signed [PW2-1:0] p4_q [3][4];
  qmr_pkg::term_ctl_t    c4 [4];

  // stage 5: output register
  logic signed [S2-1:0]  s2_sum [3];
  logic signed [DW-1:0]  r5_d [3];
  logic                  ov5_d;
  logic                  v5_q, op5_q, ov5_q;
  logic signed [DW-1:0]  rw5_q;
  logic signed [DW-1:0]  r5_q [3];

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= start_i && !busy_o;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // ---- stage 1
  always_ff @(posedge clk_i) begin
    op1_q   <= req_type_i;
    a1_q[0] <= a_w_i;
    a1_q[1] <= a_x_i;
    a1_q[2] <= a_y_i;
    a1_q[3] <= a_z_i;
    b1_q[0] <= b_w_i;
    b1_q[1] <= b_x_i;
    b1_q[2] <= b_y_i;
    b1_q[3] <= b_z_i;
  end

  // ---- stage 2
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        p2_d[i][j] = PW1'(a1_q[i]) * PW1'(b1_q[j]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op2_q <= op1_q;
    a2_q  <= a1_q;
    p2_q  <= p2_d;
  end

  // ---- stage 3: lane 0..3 = w, x, y, z; p2_q[i][j] = a_i * b_j
  always_comb begin
    // hamilton product b * a
    sel_p[0] = '{p2_q[0][0], p2_q[1][1], p2_q[2][2], p2_q[3][3]};
    sel_c[0] = '{qmr_pkg::T_ADD, qmr_pkg::T_SUB, qmr_pkg::T_SUB, qmr_pkg::T_SUB};
    sel_p[1] = '{p2_q[0][1], p2_q[1][0], p2_q[3][2], p2_q[2][3]};
    sel_c[1] = '{qmr_pkg::T_ADD, qmr_pkg::T_ADD, qmr_pkg::T_ADD, qmr_pkg::T_SUB};
    sel_p[2] = '{p2_q[0][2], p2_q[2][0], p2_q[1][3], p2_q[3][1]};
    sel_c[2] = '{qmr_pkg::T_ADD, qmr_pkg::T_ADD, qmr_pkg::T_ADD, qmr_pkg::T_SUB};
    sel_p[3] = '{p2_q[0][3], p2_q[3][0], p2_q[2][1], p2_q[1][2]};
    sel_c[3] = '{qmr_pkg::T_ADD, qmr_pkg::T_ADD, qmr_pkg::T_ADD, qmr_pkg::T_SUB};
    case (op2_q)
      qmr_pkg::OP_ROTATE: begin
        // t = a * (0, v); the -a_x*b_x term is floored after negation
        sel_p[0] = '{p2_q[1][1], p2_q[2][2], p2_q[3][3], '0};
        sel_c[0] = '{qmr_pkg::T_NEGADD, qmr_pkg::T_SUB, qmr_pkg::T_SUB, qmr_pkg::T_ADD};
        sel_p[1] = '{p2_q[0][1], p2_q[2][3], p2_q[3][2], '0};
        sel_c[1] = '{qmr_pkg::T_ADD, qmr_pkg::T_ADD, qmr_pkg::T_SUB, qmr_pkg::T_ADD};
        sel_p[2] = '{p2_q[0][2], p2_q[3][1], p2_q[1][3], '0};
        sel_c[2] = '{qmr_pkg::T_ADD, qmr_pkg::T_ADD, qmr_pkg::T_SUB, qmr_pkg::T_ADD};
        sel_p[3] = '{p2_q[0][3], p2_q[1][2], p2_q[2][1], '0};
        sel_c[3] = '{qmr_pkg::T_ADD, qmr_pkg::T_ADD, qmr_pkg::T_SUB, qmr_pkg::T_ADD};
      end
      default: begin
      end
    endcase
  end

  for (genvar k = 0; k < 4; k++) begin : g_dot1
    qmr_dot4 #(
      .PW   (PW1),
      .FRAC (F)
    ) u_dot (
      .prod_i (sel_p[k]),
      .ctl_i  (sel_c[k]),
      .sum_o  (s1_sum[k])
    );
  end

  always_comb begin
    ov3_d = 1'b0;
    for (int k = 0; k < 4; k++) begin
      s1_sat[k] = s1_sum[k];
      if (op2_q == qmr_pkg::OP_ROTATE) begin
        if (s1_sum[k] > S1_IMAX) begin
          s1_sat[k] = S1_IMAX;
          ov3_d     = 1'b1;
        end else if (s1_sum[k] < S1_IMIN) begin
          s1_sat[k] = S1_IMIN;
          ov3_d     = 1'b1;
        end
      end else begin
        if (s1_sum[k] > S1_DMAX) begin
          s1_sat[k] = S1_DMAX;
          ov3_d     = 1'b1;
        end else if (s1_sum[k] < S1_DMIN) begin
          s1_sat[k] = S1_DMIN;
          ov3_d     = 1'b1;
        end
      end
      t3_d[k] = s1_sat[k][IW-1:0];
    end
    // +a_w, then conj vector part -a_x, -a_y, -a_z, exact
    qa3_d[0] = (DW+1)'(a2_q[0]);
    for (int k = 1; k < 4; k++) begin
      qa3_d[k] = -((DW+1)'(a2_q[k]));
    end
  end

  always_ff @(posedge clk_i) begin
    op3_q <= op2_q;
    ov3_q <= ov3_d;
    qa3_q <= qa3_d;
    t3_q  <= t3_d;
  end

  // ---- stage 4: r = t * conj(a), t index 0..3 = w, x, y, z
  always_comb begin
    p4_d[0][0] = PW2'(t3_q[1]) * PW2'(qa3_q[0]);
    p4_d[0][1] = PW2'(t3_q[0]) * PW2'(qa3_q[1]);
    p4_d[0][2] = PW2'(t3_q[2]) * PW2'(qa3_q[3]);
    p4_d[0][3] = PW2'(t3_q[3]) * PW2'(qa3_q[2]);
    p4_d[1][0] = PW2'(t3_q[2]) * PW2'(qa3_q[0]);
    p4_d[1][1] = PW2'(t3_q[0]) * PW2'(qa3_q[2]);
    p4_d[1][2] = PW2'(t3_q[3]) * PW2'(qa3_q[1]);
    p4_d[1][3] = PW2'(t3_q[1]) * PW2'(qa3_q[3]);
    p4_d[2][0] = PW2'(t3_q[3]) * PW2'(qa3_q[0]);
    p4_d[2][1] = PW2'(t3_q[0]) * PW2'(qa3_q[3]);
    p4_d[2][2] = PW2'(t3_q[1]) * PW2'(qa3_q[2]);
    p4_d[2][3] = PW2'(t3_q[2]) * PW2'(qa3_q[1]);
  end

  always_ff @(posedge clk_i) begin
    op4_q <= op3_q;
    ov4_q <= ov3_q;
    t4_q  <= t3_q;
    p4_q  <= p4_d;
  end

  // ---- stage 5
  assign c4 = '{qmr_pkg::T_ADD, qmr_pkg::T_ADD, qmr_pkg::T_ADD, qmr_pkg::T_SUB};

  for (genvar k = 0; k < 3; k++) begin : g_dot2
    qmr_dot4 #(
      .PW   (PW2),
      .FRAC (F)
    ) u_dot (
      .prod_i (p4_q[k]),
      .ctl_i  (c4),
      .sum_o  (s2_sum[k])
    );
  end

  always_comb begin
    ov5_d = ov4_q;
    for (int k = 0; k < 3; k++) begin
      if (op4_q == qmr_pkg::OP_ROTATE) begin
        if (s2_sum[k] > S2_DMAX) begin
          r5_d[k] = S2_DMAX[DW-1:0];
          ov5_d   = 1'b1;
        end else if (s2_sum[k] < S2_DMIN) begin
          r5_d[k] = S2_DMIN[DW-1:0];
          ov5_d   = 1'b1;
        end else begin
          r5_d[k] = s2_sum[k][DW-1:0];
        end
      end else begin
        // product result was clamped in stage 3
        r5_d[k] = t4_q[k+1][DW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op5_q <= op4_q;
    ov5_q <= ov5_d;
    rw5_q <= (op4_q == qmr_pkg::OP_ROTATE) ? '0 : t4_q[0][DW-1:0];
    r5_q  <= r5_d;
  end

  assign done_o     = v5_q;
  assign r_w_o      = rw5_q;
  assign r_x_o      = r5_q[0];
  assign r_y_o      = r5_q[1];
  assign r_z_o      = r5_q[2];
  assign overflow_o = ov5_q;

  // every accepted beat comes out on done_o
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##5 done_o)
    else $error("accepted beat did not come out after five cycles");

  // the operation code stays with its beat through the pipe
  a_op_track : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##5 (op5_q == $past(req_type_i, 5)))
    else $error("operation code lost its beat");

  // a rotation never shows a nonzero scalar part
  a_rot_w_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (op5_q == qmr_pkg::OP_ROTATE) |-> (r_w_o == '0))
    else $error("rotation result with nonzero w");

  // no result without a valid beat in stage 4 before it
  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(v4_q))
    else $error("result strobe without a beat in flight");

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps

module tb;

  localparam int DW         = 16;
  localparam int FRAC       = 14;
  localparam int IW         = DW + 4;
  localparam int RAND_ITEMS = 450;
  localparam int QUIET_TAIL = 80;
  localparam int CYCLE_CAP  = 200000;

  typedef struct packed {
    logic                 op;
    logic signed [DW-1:0] aw, ax, ay, az;
    logic signed [DW-1:0] bw, bx, by, bz;
  } qreq_t;

  typedef struct packed {
    logic signed [DW-1:0] w, x, y, z;
    logic                 ovf;
  } qres_t;

  typedef struct {
    qreq_t req;
    bit    typed;
    qres_t res;
  } stim_row_t;

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 start_i = 1'b0;
  logic                 busy_o;
  logic                 req_type_i = qmr_pkg::OP_PRODUCT;
  logic signed [DW-1:0] a_w_i = '0, a_x_i = '0, a_y_i = '0, a_z_i = '0;
  logic signed [DW-1:0] b_w_i = '0, b_x_i = '0, b_y_i = '0, b_z_i = '0;
  logic                 done_o;
  logic signed [DW-1:0] r_w_o, r_x_o, r_y_o, r_z_o;
  logic                 overflow_o;

  qres_t       pending_results[$];
  bit          beat_taken = 1'b0;
  bit          use_typed = 1'b0;
  qres_t       typed_res;
  int unsigned fail_count = 0;
  int unsigned cycle_cnt = 0;

  quaternion_multiply_rotate_unit #(
    .FRAC_BITS (FRAC),
    .DATA_WIDTH(DW)
  ) uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .busy_o    (busy_o),
    .req_type_i(req_type_i),
    .a_w_i     (a_w_i),
    .a_x_i     (a_x_i),
    .a_y_i     (a_y_i),
    .a_z_i     (a_z_i),
    .b_w_i     (b_w_i),
    .b_x_i     (b_x_i),
    .b_y_i     (b_y_i),
    .b_z_i     (b_z_i),
    .done_o    (done_o),
    .r_w_o     (r_w_o),
    .r_x_o     (r_x_o),
    .r_y_o     (r_y_o),
    .r_z_o     (r_z_o),
    .overflow_o(overflow_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // exact product, floored by the arithmetic shift
  function automatic longint fx_mul(longint p, longint q);
    return (p * q) >>> FRAC;
  endfunction

  function automatic longint clamp(longint v, int w, inout bit ovf);
    longint hi, lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      ovf = 1'b1;
      return hi;
    end
    if (v < lo) begin
      ovf = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic qres_t quat_result(qreq_t r);
    longint qw, qx, qy, qz, bw, bx, by, bz, nx, ny, nz;
    longint tw, tx, ty, tz, rw, rx, ry, rz;
    bit     ovf;
    qres_t  res;
    ovf = 1'b0;
    qw = longint'(r.aw); qx = longint'(r.ax); qy = longint'(r.ay); qz = longint'(r.az);
    bw = longint'(r.bw); bx = longint'(r.bx); by = longint'(r.by); bz = longint'(r.bz);
    if (r.op == qmr_pkg::OP_PRODUCT) begin
      rw = fx_mul(qw, bw) - fx_mul(qx, bx) - fx_mul(qy, by) - fx_mul(qz, bz);
      rx = fx_mul(qw, bx) + fx_mul(qx, bw) + fx_mul(qz, by) - fx_mul(qy, bz);
      ry = fx_mul(qw, by) + fx_mul(qy, bw) + fx_mul(qx, bz) - fx_mul(qz, bx);
      rz = fx_mul(qw, bz) + fx_mul(qz, bw) + fx_mul(qy, bx) - fx_mul(qx, by);
      rw = clamp(rw, DW, ovf);
    end else begin
      // conj(A) parts are negated one bit wider, then floored per product
      nx = -qx; ny = -qy; nz = -qz;
      tx = clamp(fx_mul(qw, bx) + fx_mul(qy, bz) - fx_mul(qz, by), IW, ovf);
      ty = clamp(fx_mul(qw, by) + fx_mul(qz, bx) - fx_mul(qx, bz), IW, ovf);
      tz = clamp(fx_mul(qw, bz) + fx_mul(qx, by) - fx_mul(qy, bx), IW, ovf);
      tw = clamp(fx_mul(nx, bx) - fx_mul(qy, by) - fx_mul(qz, bz), IW, ovf);
      rx = fx_mul(tx, qw) + fx_mul(tw, nx) + fx_mul(ty, nz) - fx_mul(tz, ny);
      ry = fx_mul(ty, qw) + fx_mul(tw, ny) + fx_mul(tz, nx) - fx_mul(tx, nz);
      rz = fx_mul(tz, qw) + fx_mul(tw, nz) + fx_mul(tx, ny) - fx_mul(ty, nx);
      rw = 0;
    end
    rx = clamp(rx, DW, ovf);
    ry = clamp(ry, DW, ovf);
    rz = clamp(rz, DW, ovf);
    res.w = DW'(rw); res.x = DW'(rx); res.y = DW'(ry); res.z = DW'(rz);
    res.ovf = ovf;
    return res;
  endfunction

  function automatic stim_row_t mk_row(logic op, int aw, int ax, int ay, int az,
                                       int bw, int bx, int by, int bz, bit typed,
                                       int rw, int rx, int ry, int rz, bit ovf);
    stim_row_t row;
    row.req = '{op: op, aw: DW'(aw), ax: DW'(ax), ay: DW'(ay), az: DW'(az),
                bw: DW'(bw), bx: DW'(bx), by: DW'(by), bz: DW'(bz)};
    row.typed = typed;
    row.res = '{w: DW'(rw), x: DW'(rx), y: DW'(ry), z: DW'(rz), ovf: ovf};
    return row;
  endfunction

  function automatic logic signed [DW-1:0] rand_comp(int unsigned kind);
    int ext[6];
    ext = '{-32768, -1, 0, 1, 16384, 32767};
    case (kind)
      0: return DW'($urandom_range(0, 32768) - 16384);
      1: return DW'($urandom_range(0, 128) - 64);
      2: return DW'(ext[$urandom_range(0, 5)]);
      default: return DW'($urandom);
    endcase
  endfunction

  task automatic check_field(input string fname, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      fail_count++;
    end
  endtask

  task automatic send_beat(input qreq_t r);
    start_i    <= 1'b1;
    req_type_i <= r.op;
    a_w_i      <= r.aw;
    a_x_i      <= r.ax;
    a_y_i      <= r.ay;
    a_z_i      <= r.az;
    b_w_i      <= r.bw;
    b_x_i      <= r.bx;
    b_y_i      <= r.by;
    b_z_i      <= r.bz;
    do @(negedge clk_i); while (!beat_taken);
  endtask

  task automatic idle_burst(input int unsigned cycles);
    start_i <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    qreq_t seen;
    qres_t want;
    if (!rst_ni) begin
      beat_taken = 1'b0;
    end else begin
      if (done_o) begin
        if (pending_results.size() == 0) begin
          $error("result beat with nothing outstanding");
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("r_w", longint'(want.w), longint'(r_w_o));
          check_field("r_x", longint'(want.x), longint'(r_x_o));
          check_field("r_y", longint'(want.y), longint'(r_y_o));
          check_field("r_z", longint'(want.z), longint'(r_z_o));
          check_field("overflow", longint'(want.ovf), longint'(overflow_o));
        end
      end
      beat_taken = start_i && !busy_o;
      if (beat_taken) begin
        seen = '{op: req_type_i, aw: a_w_i, ax: a_x_i, ay: a_y_i, az: a_z_i,
                 bw: b_w_i, bx: b_x_i, by: b_y_i, bz: b_z_i};
        pending_results.push_back(use_typed ? typed_res : quat_result(seen));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("quaternion_multiply_rotate_unit: mismatch");
      $finish;
    end
  end

  initial begin
    stim_row_t   stim_rows[$];
    qreq_t       req;
    int unsigned kind;
    // zero operands
    stim_rows.push_back(mk_row(qmr_pkg::OP_PRODUCT, 0, 0, 0, 0, 0, 0, 0, 0,
                               1, 0, 0, 0, 0, 0));
    stim_rows.push_back(mk_row(qmr_pkg::OP_ROTATE, 0, 0, 0, 0, 0, 0, 0, 0,
                               1, 0, 0, 0, 0, 0));
    // identity A passes B through; rotation ignores b_w
    stim_rows.push_back(mk_row(qmr_pkg::OP_PRODUCT, 16384, 0, 0, 0, 32767, -32768, 1, -1,
                               1, 32767, -32768, 1, -1, 0));
    stim_rows.push_back(mk_row(qmr_pkg::OP_ROTATE, 16384, 0, 0, 0, 12345, -32768, 32767, -1,
                               1, 0, -32768, 32767, -1, 0));
    // most negative everywhere saturates all four parts
    stim_rows.push_back(mk_row(qmr_pkg::OP_PRODUCT, -32768, -32768, -32768, -32768,
                               -32768, -32768, -32768, -32768,
                               1, -32768, 32767, 32767, 32767, 1));
    // floor rounding of a tiny negative product
    stim_rows.push_back(mk_row(qmr_pkg::OP_PRODUCT, -1, 0, 0, 0, 1, 1, 1, 1,
                               1, -1, -1, -1, -1, 0));
    stim_rows.push_back(mk_row(qmr_pkg::OP_ROTATE, -32768, -32768, -32768, -32768,
                               -32768, -32768, -32768, -32768, 0, 0, 0, 0, 0, 0));
    stim_rows.push_back(mk_row(qmr_pkg::OP_ROTATE, 32767, 32767, 32767, 32767,
                               32767, 32767, 32767, 32767, 0, 0, 0, 0, 0, 0));
    stim_rows.push_back(mk_row(qmr_pkg::OP_PRODUCT, 32767, 32767, 32767, 32767,
                               32767, 32767, 32767, 32767, 0, 0, 0, 0, 0, 0));
    // quarter turn about z
    stim_rows.push_back(mk_row(qmr_pkg::OP_ROTATE, 11585, 0, 0, 11585, 0, 16384, 0, 0,
                               0, 0, 0, 0, 0, 0));
    stim_rows.push_back(mk_row(qmr_pkg::OP_PRODUCT, 0, 16384, 0, 0, 0, 0, 16384, 0,
                               0, 0, 0, 0, 0, 0));
    // unnormalized A scales the vector past full range
    stim_rows.push_back(mk_row(qmr_pkg::OP_ROTATE, 32767, 0, 0, 0, 0, 32767, -32768, 16384,
                               0, 0, 0, 0, 0, 0));
    stim_rows.push_back(mk_row(qmr_pkg::OP_PRODUCT, 32767, -32768, 32767, -32768,
                               -32768, 32767, -32768, 32767, 0, 0, 0, 0, 0, 0));
    stim_rows.push_back(mk_row(qmr_pkg::OP_ROTATE, 0, 32767, 32767, 32767,
                               -32768, 100, -200, 300, 0, 0, 0, 0, 0, 0));
    stim_rows.push_back(mk_row(qmr_pkg::OP_ROTATE, -1, 1, -1, 1, 32767, -3, 5, -7,
                               0, 0, 0, 0, 0, 0));

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (stim_rows[i]) begin
      if ($urandom_range(0, 2) == 0) idle_burst($urandom_range(1, 17));
      use_typed = stim_rows[i].typed;
      typed_res = stim_rows[i].res;
      send_beat(stim_rows[i].req);
    end
    use_typed = 1'b0;

    for (int n = 0; n < RAND_ITEMS; n++) begin
      // no gaps in the tail so results stream back to back
      if (n < RAND_ITEMS - QUIET_TAIL && $urandom_range(0, 3) == 0)
        idle_burst($urandom_range(1, 17));
      kind = $urandom_range(0, 9);
      kind = (kind < 4) ? 3 : (kind < 8) ? 0 : (kind == 8) ? 1 : 2;
      req.op = 1'($urandom_range(0, 1));
      req.aw = rand_comp(kind);
      req.ax = rand_comp(kind);
      req.ay = rand_comp(kind);
      req.az = rand_comp(kind);
      req.bw = rand_comp(kind);
      req.bx = rand_comp(kind);
      req.by = rand_comp(kind);
      req.bz = rand_comp(kind);
      send_beat(req);
    end
    start_i <= 1'b0;

    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);

    if (fail_count == 0) begin
      $display("quaternion_multiply_rotate_unit: match");
    end else begin
      $display("quaternion_multiply_rotate_unit: mismatch");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/qmr_pkg.sv
rtl/qmr_dot4.sv
rtl/quaternion_multiply_rotate_unit.sv
dv/tb.sv
